FILE: rtl/core/fbfa_pkg.sv
// Shared types and constants of the fragment best-fit allocator.
// Depends on nothing; imported by the allocator core.
package fbfa_pkg;

    localparam int TABLE_W   = 32;
    localparam int BLOCK_W   = 32;
    localparam int LEN_W     = 17;
    localparam int ALEN_W    = 18;
    localparam int OFFSET_W  = 17;
    localparam int FRAG_W    = 7;
    localparam int BSIZE_W   = 17;
    localparam int MAXOPEN_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam int DEF_MAX_ENTRIES     = 16;
    localparam int DEF_FRAGS_PER_BLOCK = 64;
    localparam int HEADER_BYTES        = 24;

    localparam logic [BSIZE_W-1:0]   RST_BLOCK_SIZE = 17'd4096;
    localparam logic [MAXOPEN_W-1:0] RST_MAX_OPEN   = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 1'b0,
        CFG_MAX_OPEN   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

endpackage

FILE: rtl/core/fbfa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module fbfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/fragment_best_fit_allocator_core.sv
// Top level of the fragment best-fit allocator: sequencer, scan and commit logic.
// Depends on fbfa_pkg and on fbfa_ram, which holds the table of open blocks.
//
// A request is taken when start is high and busy is low. The table of open
// blocks lives in one RAM whose single read port is swept over the N open
// entries in state SCAN, one entry per cycle, with N up to MAX_ENTRIES.
// DECIDE and COMMIT follow, and the result strobe comes from a register set
// in COMMIT; with no block open yet, SCAN and DECIDE are skipped. A new
// request can be taken at the edge that ends the result strobe. A request
// longer than a fresh block holds is answered on the next cycle with
// too_large set. Each result is shown for exactly one cycle with
// o_result_valid; the receiver cannot stall it. Configuration
// writes take effect at once and belong in idle time. After reset the RAM
// content is unknown, but only entries below the open count are ever read,
// so no clearing pass is needed.
module fragment_best_fit_allocator_core #(
    parameter int MAX_ENTRIES     = fbfa_pkg::DEF_MAX_ENTRIES,
    parameter int FRAGS_PER_BLOCK = fbfa_pkg::DEF_FRAGS_PER_BLOCK
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [fbfa_pkg::TABLE_W-1:0]     i_owner_table,
    input  logic [fbfa_pkg::LEN_W-1:0]       i_request_length,
    input  logic [fbfa_pkg::BLOCK_W-1:0]     i_spare_block,
    input  logic                             i_cfg_we,
    input  logic [fbfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_result_valid,
    output logic [fbfa_pkg::BLOCK_W-1:0]     o_block_number,
    output logic [fbfa_pkg::FRAG_W-1:0]      o_fragment_number,
    output logic [fbfa_pkg::OFFSET_W-1:0]    o_byte_offset,
    output logic                             o_opened_new,
    output logic                             o_retired_valid,
    output logic [fbfa_pkg::BLOCK_W-1:0]     o_retired_block,
    output logic                             o_too_large
);
    import fbfa_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W = $clog2(FRAGS_PER_BLOCK + 2);
    localparam int CMP_W  = CNT_W + MAXOPEN_W;
    localparam int OVERHEAD = HEADER_BYTES + 4 * FRAGS_PER_BLOCK;
    localparam int FRESH_OFFSET = (4 * (FRAGS_PER_BLOCK + 5)) % 131072;
    localparam int SCORE_W = ALEN_W + 1;
    localparam int FF_W = 20;

    typedef struct packed {
        logic [BLOCK_W-1:0]  blk;
        logic [TABLE_W-1:0]  tbl;
        logic [OFFSET_W-1:0] free;
        logic [OFFSET_W-1:0] offset;
        logic [SLOT_W-1:0]   slot;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Configuration.
    logic [BSIZE_W-1:0]   r_block_size;
    logic [MAXOPEN_W-1:0] r_max_open;

    // Sequencer and request.
    t_state              r_state;
    logic [CNT_W-1:0]    r_open_cnt;
    logic [CNT_W-1:0]    r_addr;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [TABLE_W-1:0]  r_table;
    logic [ALEN_W-1:0]   r_len;
    logic [BLOCK_W-1:0]  r_spare;

    // Scan results.
    logic                       r_best_vld;
    logic [IDX_W-1:0]           r_best_idx;
    logic [ALEN_W-1:0]          r_best_x;
    t_rec                       r_best;
    logic                       r_worst_vld;
    logic [IDX_W-1:0]           r_worst_idx;
    logic signed [SCORE_W-1:0]  r_worst_x;
    logic [BLOCK_W-1:0]         r_worst_blk;

    // Result registers.
    logic                 r_out_vld;
    logic [BLOCK_W-1:0]   r_out_block;
    logic [FRAG_W-1:0]    r_out_frag;
    logic [OFFSET_W-1:0]  r_out_offset;
    logic                 r_out_opened;
    logic                 r_out_retired;
    logic [BLOCK_W-1:0]   r_out_ret_blk;
    logic                 r_out_too_large;

    logic                       accept;
    logic [ALEN_W-1:0]          in_len;
    logic signed [FF_W-1:0]     fresh_free;
    logic                       in_too_large;
    logic [CMP_W-1:0]           mo_ext;
    logic [CMP_W-1:0]           limit;
    logic                       below_limit;

    logic                       ram_re;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    t_rec                       ram_wrec;
    t_rec                       rd_rec;
    logic [REC_W-1:0]           ram_rdata;

    logic signed [SCORE_W-1:0]  x;
    logic                       best_hit;
    logic                       worst_hit;

    t_rec                       cur;
    logic [IDX_W-1:0]           sel_idx;
    logic [ALEN_W:0]            free_diff;
    logic [OFFSET_W-1:0]        n_free;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign in_len = (ALEN_W'(i_request_length) + ALEN_W'(3)) & ~ALEN_W'(3);

    // A fresh block's payload space; negative when the block size is too small.
    assign fresh_free   = $signed(FF_W'(r_block_size)) - $signed(FF_W'(OVERHEAD));
    assign in_too_large = $signed(FF_W'(in_len)) > fresh_free;

    // Effective limit of open blocks, clamped to 1..MAX_ENTRIES.
    always_comb begin
        mo_ext = CMP_W'(r_max_open);
        priority if (mo_ext == '0) begin
            limit = CMP_W'(1);
        end else if (mo_ext > CMP_W'(MAX_ENTRIES)) begin
            limit = CMP_W'(MAX_ENTRIES);
        end else begin
            limit = mo_ext;
        end
    end
    assign below_limit = CMP_W'(r_open_cnt) < limit;

    // Scan: score of the entry returned by the RAM this cycle.
    assign rd_rec    = t_rec'(ram_rdata);
    assign x         = $signed({2'b00, rd_rec.free}) - $signed({1'b0, r_len});
    assign best_hit  = (rd_rec.tbl == r_table) && !x[SCORE_W-1]
                    && (!r_best_vld || (x[ALEN_W-1:0] < r_best_x))
                    && (rd_rec.slot <= SLOT_W'(FRAGS_PER_BLOCK));
    assign worst_hit = !r_worst_vld || (x < r_worst_x);

    // Commit: pick the entry and build its updated record.
    always_comb begin
        if (r_best_vld) begin
            cur     = r_best;
            sel_idx = r_best_idx;
        end else begin
            cur.blk    = r_spare;
            cur.tbl    = r_table;
            cur.free   = fresh_free[OFFSET_W-1:0];
            cur.offset = OFFSET_W'(FRESH_OFFSET);
            cur.slot   = SLOT_W'(1);
            sel_idx    = below_limit ? r_open_cnt[IDX_W-1:0] : r_worst_idx;
        end
        free_diff = {2'b00, cur.free} - {1'b0, r_len};
        if (free_diff[ALEN_W]) begin
            n_free = '0;
        end else begin
            n_free = free_diff[OFFSET_W-1:0];
        end
        ram_wrec     = cur;
        ram_wrec.tbl = r_table;
        ram_wrec.offset = OFFSET_W'(cur.offset + OFFSET_W'(r_len));
        ram_wrec.free = (cur.slot == SLOT_W'(FRAGS_PER_BLOCK)) ? '0 : n_free;
        if (cur.slot <= SLOT_W'(FRAGS_PER_BLOCK)) begin
            ram_wrec.slot = cur.slot + SLOT_W'(1);
        end
        ram_waddr = sel_idx;
    end

    assign ram_we = (r_state == S_COMMIT);
    assign ram_re = (r_state == S_SCAN);

    fbfa_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (REC_W'(ram_wrec)),
        .i_re    (ram_re),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= RST_BLOCK_SIZE;
            r_max_open   <= RST_MAX_OPEN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[BSIZE_W-1:0];
                CFG_MAX_OPEN:   r_max_open   <= i_cfg_data[MAXOPEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_open_cnt <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld  <= ram_re;
            r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (in_too_large) begin
                            r_out_vld <= 1'b1;
                        end else if (r_open_cnt == '0) begin
                            r_state <= S_COMMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_addr + CNT_W'(1) == r_open_cnt) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_state   <= S_IDLE;
                    r_out_vld <= 1'b1;
                    if (!r_best_vld && below_limit) begin
                        r_open_cnt <= r_open_cnt + CNT_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Request capture, scan bookkeeping and results.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_table     <= i_owner_table;
            r_len       <= in_len;
            r_spare     <= i_spare_block;
            r_addr      <= '0;
            r_best_vld  <= 1'b0;
            r_worst_vld <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_addr   <= r_addr + CNT_W'(1);
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (r_rd_vld) begin
            if (best_hit) begin
                r_best_vld <= 1'b1;
                r_best_idx <= r_rd_idx;
                r_best_x   <= x[ALEN_W-1:0];
                r_best     <= rd_rec;
            end
            if (worst_hit) begin
                r_worst_vld <= 1'b1;
                r_worst_idx <= r_rd_idx;
                r_worst_x   <= x;
                r_worst_blk <= rd_rec.blk;
            end
        end
        if (accept && in_too_large) begin
            r_out_block     <= '0;
            r_out_frag      <= '0;
            r_out_offset    <= '0;
            r_out_opened    <= 1'b0;
            r_out_retired   <= 1'b0;
            r_out_ret_blk   <= '0;
            r_out_too_large <= 1'b1;
        end else if (r_state == S_COMMIT) begin
            r_out_block     <= cur.blk;
            r_out_frag      <= FRAG_W'(cur.slot);
            r_out_offset    <= cur.offset;
            r_out_opened    <= !r_best_vld;
            r_out_retired   <= !r_best_vld && !below_limit;
            r_out_ret_blk   <= (!r_best_vld && !below_limit) ? r_worst_blk : '0;
            r_out_too_large <= 1'b0;
        end
    end

    assign o_result_valid    = r_out_vld;
    assign o_block_number    = r_out_block;
    assign o_fragment_number = r_out_frag;
    assign o_byte_offset     = r_out_offset;
    assign o_opened_new      = r_out_opened;
    assign o_retired_valid   = r_out_retired;
    assign o_retired_block   = r_out_ret_blk;
    assign o_too_large       = r_out_too_large;

`ifndef SYNTHESIS
    // The open count can never pass the table depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_open_cnt) <= CNT_W'(MAX_ENTRIES))
        else $error("open count exceeds table depth");

    // The read pipeline is drained before an entry is written back.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> !r_rd_vld)
        else $error("commit with a read still in flight");

    // Every result beat follows a commit or a rejected request.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> ($past(r_state == S_COMMIT) || $past(accept)))
        else $error("result without a request");

    // A chosen best fit always has a free fragment slot.
    a_best_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_best_vld) |->
            (r_best.slot <= SLOT_W'(FRAGS_PER_BLOCK)))
        else $error("best fit entry has no slot left");

    // Appending a block grows the open count by one.
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && !r_best_vld && below_limit) |=>
            (r_open_cnt == $past(r_open_cnt) + CNT_W'(1)))
        else $error("append did not grow the open count");
`endif

endmodule
